@@ sv/ftc_pkg.sv @@
// ----------------------------------------------------------------------------
// ftc_pkg
// Types and constants shared by the FAT timestamp calendar counter.
// ----------------------------------------------------------------------------
package ftc_pkg;

  localparam int unsigned UNITS_W  = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 7;
  localparam int unsigned CAL_YEAR_W = 12;
  localparam int unsigned SECOND_W = 6;

  localparam logic [CAL_YEAR_W-1:0] EPOCH_YEAR    = 12'd1980;
  localparam logic [UNITS_W-1:0]    UNITS_PER_MIN = 5'd30;
  localparam logic [MINUTE_W-1:0]   MINS_PER_HOUR = 6'd60;
  localparam logic [HOUR_W-1:0]     HOURS_PER_DAY = 5'd24;
  localparam logic [MONTH_W:0]      MONTH_LIMIT   = 5'd13;

  // request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // field order matches the packed FAT word, year in the top bits
  typedef struct packed {
    logic [YEAR_W-1:0]   year_offset;
    logic [MONTH_W-1:0]  month_count;
    logic [DAY_W-1:0]    day_count;
    logic [HOUR_W-1:0]   hour_count;
    logic [MINUTE_W-1:0] minute_count;
    logic [UNITS_W-1:0]  two_sec_units;
  } cal_state_t;

  typedef struct packed {
    logic                  req_type;
    logic [CAL_YEAR_W-1:0] set_year;
    logic [MONTH_W-1:0]    set_month;
    logic [DAY_W-1:0]      set_day;
    logic [HOUR_W-1:0]     set_hour;
    logic [MINUTE_W-1:0]   set_minute;
    logic [SECOND_W-1:0]   set_second;
  } cal_req_t;

endpackage

@@ sv/ftc_step.sv @@
// ----------------------------------------------------------------------------
// ftc_step
// Next calendar state for one request: load the given date and time, or
// advance by two seconds with carries through to the year.
// ----------------------------------------------------------------------------
module ftc_step (
  input  ftc_pkg::cal_state_t cur,
  input  ftc_pkg::cal_req_t   req,
  output ftc_pkg::cal_state_t nxt
);

  // year offset of 2100, the only non-leap multiple of four in range
  localparam logic [ftc_pkg::YEAR_W-1:0] OFFS_2100 = 7'd120;

  logic [ftc_pkg::UNITS_W-1:0]  units_inc;
  logic [ftc_pkg::MINUTE_W-1:0] minute_inc;
  logic [ftc_pkg::HOUR_W-1:0]   hour_inc;
  logic [ftc_pkg::DAY_W:0]      day_inc;
  logic [ftc_pkg::MONTH_W:0]    month_inc;
  logic [ftc_pkg::DAY_W-1:0]    month_len;
  logic                         leap;
  logic                         carry_min, carry_hour, carry_day, carry_month, carry_year;
  logic [ftc_pkg::CAL_YEAR_W-1:0] year_diff;
  ftc_pkg::cal_state_t          ticked;

  always_comb begin
    units_inc  = cur.two_sec_units + 1'b1;
    minute_inc = cur.minute_count + 1'b1;
    hour_inc   = cur.hour_count + 1'b1;
    day_inc    = {1'b0, cur.day_count} + 1'b1;
    month_inc  = {1'b0, cur.month_count} + 1'b1;

    leap = (cur.year_offset[1:0] == 2'b00) && (cur.year_offset != OFFS_2100);

    case (cur.month_count)
      4'd2:                      month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase

    carry_min   = (units_inc == ftc_pkg::UNITS_PER_MIN);
    carry_hour  = carry_min && (minute_inc == ftc_pkg::MINS_PER_HOUR);
    carry_day   = carry_hour && (hour_inc == ftc_pkg::HOURS_PER_DAY);
    carry_month = carry_day && (day_inc > {1'b0, month_len});
    carry_year  = carry_month && (month_inc >= ftc_pkg::MONTH_LIMIT);

    ticked = cur;
    ticked.two_sec_units = carry_min ? '0 : units_inc;
    if (carry_min) begin
      ticked.minute_count = carry_hour ? '0 : minute_inc;
    end
    if (carry_hour) begin
      ticked.hour_count = carry_day ? '0 : hour_inc;
    end
    if (carry_day) begin
      ticked.day_count = carry_month ? 5'd1 : day_inc[ftc_pkg::DAY_W-1:0];
    end
    if (carry_month) begin
      ticked.month_count = carry_year ? 4'd1 : month_inc[ftc_pkg::MONTH_W-1:0];
    end
    if (carry_year) begin
      ticked.year_offset = cur.year_offset + 1'b1;
    end

    year_diff = req.set_year - ftc_pkg::EPOCH_YEAR;

    if (req.req_type == ftc_pkg::REQ_LOAD) begin
      nxt.year_offset   = year_diff[ftc_pkg::YEAR_W-1:0];
      nxt.month_count   = req.set_month;
      nxt.day_count     = req.set_day;
      nxt.hour_count    = req.set_hour;
      nxt.minute_count  = req.set_minute;
      nxt.two_sec_units = req.set_second[ftc_pkg::SECOND_W-1:1];
    end else begin
      nxt = ticked;
    end
  end

endmodule

@@ sv/fat_timestamp_calendar_counter.sv @@
// ----------------------------------------------------------------------------
// fat_timestamp_calendar_counter
// Calendar kept in the packed FAT timestamp layout, updated by load and
// two-second tick requests; each request returns the packed word.
// ----------------------------------------------------------------------------
// path: an input register, then the calendar register that also drives the
// result
// throughput: one beat per cycle while out_ready is high; the tick carry chain is combinational
// reset: synchronous active-low rst_n clears the calendar and all valid flags
module fat_timestamp_calendar_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [11:0] in_set_year,
  input  logic [3:0]  in_set_month,
  input  logic [4:0]  in_set_day,
  input  logic [4:0]  in_set_hour,
  input  logic [5:0]  in_set_minute,
  input  logic [5:0]  in_set_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_packed_time
);

  logic                req_valid_r;
  ftc_pkg::cal_req_t   req_r;
  ftc_pkg::cal_state_t cal_r;
  ftc_pkg::cal_state_t cal_nxt;
  logic                out_valid_r;
  logic                advance;

  // the calendar register is also the result register, so it only moves
  // once the previous result beat has gone
  assign advance  = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r.req_type   <= in_req_type;
      req_r.set_year   <= in_set_year;
      req_r.set_month  <= in_set_month;
      req_r.set_day    <= in_set_day;
      req_r.set_hour   <= in_set_hour;
      req_r.set_minute <= in_set_minute;
      req_r.set_second <= in_set_second;
    end
  end

  ftc_step u_step (
    .cur (cal_r),
    .req (req_r),
    .nxt (cal_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        cal_r <= cal_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_time = cal_r;

endmodule

@@ tb/sv/fat_timestamp_calendar_counter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat_timestamp_calendar_counter_checker
// Watches both channels of the calendar counter and keeps its own copy of the
// calendar. Every accepted input beat advances that copy, and the packed word
// it gives is queued. Every result beat is compared with the oldest queued
// word. Mismatches, results with nothing queued and the queue depth are
// passed up to the testbench top.
// ----------------------------------------------------------------------------
module fat_timestamp_calendar_counter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [11:0] in_set_year,
  input  logic [3:0]  in_set_month,
  input  logic [4:0]  in_set_day,
  input  logic [4:0]  in_set_hour,
  input  logic [5:0]  in_set_minute,
  input  logic [5:0]  in_set_second,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_packed_time,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  ftc_pkg::cal_state_t calendar;
  logic [31:0]         expected_words[$];
  int unsigned         mismatches = 0;

  function automatic ftc_pkg::cal_state_t advance_calendar(ftc_pkg::cal_state_t cur,
                                                           ftc_pkg::cal_req_t   req);
    ftc_pkg::cal_state_t            nxt;
    logic [ftc_pkg::CAL_YEAR_W-1:0] year_diff;
    int unsigned                    full_year;
    int unsigned                    month_len;
    int unsigned                    next_day;
    bit                             leap;
    nxt = cur;
    if (req.req_type == ftc_pkg::REQ_LOAD) begin
      // every field is just cut to its width, nothing is range-checked
      year_diff         = req.set_year - ftc_pkg::EPOCH_YEAR;
      nxt.year_offset   = year_diff[ftc_pkg::YEAR_W-1:0];
      nxt.month_count   = req.set_month;
      nxt.day_count     = req.set_day;
      nxt.hour_count    = req.set_hour;
      nxt.minute_count  = req.set_minute;
      nxt.two_sec_units = req.set_second[ftc_pkg::SECOND_W-1:1];
    end else begin
      // seconds, minute and hour wrap at their width and carry only on an exact match
      nxt.two_sec_units = cur.two_sec_units + 1'b1;
      if (nxt.two_sec_units == ftc_pkg::UNITS_PER_MIN) begin
        nxt.two_sec_units = '0;
        nxt.minute_count  = cur.minute_count + 1'b1;
        if (nxt.minute_count == ftc_pkg::MINS_PER_HOUR) begin
          nxt.minute_count = '0;
          nxt.hour_count   = cur.hour_count + 1'b1;
          if (nxt.hour_count == ftc_pkg::HOURS_PER_DAY) begin
            nxt.hour_count = '0;
            full_year = int'(ftc_pkg::EPOCH_YEAR) + int'(cur.year_offset);
            leap = (full_year % 400 == 0) || ((full_year % 4 == 0) && (full_year % 100 != 0));
            if (cur.month_count == 4'd2) begin
              month_len = leap ? 29 : 28;
            end else if (cur.month_count == 4'd4 || cur.month_count == 4'd6 ||
                         cur.month_count == 4'd9 || cur.month_count == 4'd11) begin
              month_len = 30;
            end else begin
              month_len = 31;
            end
            // the month length is only looked at here, so an oversized loaded day
            // rolls over at the next midnight
            next_day = int'(cur.day_count) + 1;
            if (next_day > month_len) begin
              nxt.day_count = 5'd1;
              if (int'(cur.month_count) + 1 >= int'(ftc_pkg::MONTH_LIMIT)) begin
                nxt.month_count = 4'd1;
                nxt.year_offset = cur.year_offset + 1'b1;
              end else begin
                nxt.month_count = cur.month_count + 1'b1;
              end
            end else begin
              nxt.day_count = next_day[ftc_pkg::DAY_W-1:0];
            end
          end
        end
      end
    end
    return nxt;
  endfunction

  always @(posedge clk) begin : beat_monitor
    ftc_pkg::cal_req_t req_beat;
    logic [31:0]       want;
    if (!rst_n) begin
      calendar = '0;
      expected_words.delete();
    end else begin
      if (in_valid && in_ready) begin
        req_beat = {in_req_type, in_set_year, in_set_month, in_set_day,
                    in_set_hour, in_set_minute, in_set_second};
        calendar = advance_calendar(calendar, req_beat);
        expected_words.push_back(calendar);
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result beat with nothing expected, packed_time %08h",
                     $realtime, out_packed_time);
          end
        end else begin
          want = expected_words.pop_front();
          if (out_packed_time !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: packed_time mismatch, expected %08h, actual %08h",
                       $realtime, want, out_packed_time);
            end
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_words.size();
  end

endmodule

@@ tb/sv/fat_timestamp_calendar_counter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat_timestamp_calendar_counter_tb
// Drives load and tick requests into the calendar counter with random gaps
// and random result back-pressure. It runs a directed set of calendar edges
// first: month ends, leap rules, oversized fields and the year wrap. Random
// loads near carry points then follow, each with a run of ticks, mixed with
// raw random loads and runs of ticks alone. A checker beside the block
// predicts every packed word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module fat_timestamp_calendar_counter_tb;

  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned IDLE_LIMIT   = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [11:0] in_set_year;
  logic [3:0]  in_set_month;
  logic [4:0]  in_set_day;
  logic [4:0]  in_set_hour;
  logic [5:0]  in_set_minute;
  logic [5:0]  in_set_second;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_packed_time;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned beats_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          burst_mode  = 1'b0;

  fat_timestamp_calendar_counter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_set_year     (in_set_year),
    .in_set_month    (in_set_month),
    .in_set_day      (in_set_day),
    .in_set_hour     (in_set_hour),
    .in_set_minute   (in_set_minute),
    .in_set_second   (in_set_second),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_time (out_packed_time)
  );

  fat_timestamp_calendar_counter_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_set_year     (in_set_year),
    .in_set_month    (in_set_month),
    .in_set_day      (in_set_day),
    .in_set_hour     (in_set_hour),
    .in_set_minute   (in_set_minute),
    .in_set_second   (in_set_second),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_time (out_packed_time),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_request(ftc_pkg::cal_req_t req);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req.req_type;
    in_set_year   <= req.set_year;
    in_set_month  <= req.set_month;
    in_set_day    <= req.set_day;
    in_set_hour   <= req.set_hour;
    in_set_minute <= req.set_minute;
    in_set_second <= req.set_second;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic load_time(int unsigned yr, int unsigned mo, int unsigned dy,
                           int unsigned hr, int unsigned mi, int unsigned se);
    ftc_pkg::cal_req_t req;
    req.req_type   = ftc_pkg::REQ_LOAD;
    req.set_year   = yr[ftc_pkg::CAL_YEAR_W-1:0];
    req.set_month  = mo[ftc_pkg::MONTH_W-1:0];
    req.set_day    = dy[ftc_pkg::DAY_W-1:0];
    req.set_hour   = hr[ftc_pkg::HOUR_W-1:0];
    req.set_minute = mi[ftc_pkg::MINUTE_W-1:0];
    req.set_second = se[ftc_pkg::SECOND_W-1:0];
    send_request(req);
  endtask

  // the set fields carry noise, a tick must ignore them
  task automatic tick_times(int unsigned count);
    logic [63:0]       noise;
    ftc_pkg::cal_req_t req;
    repeat (count) begin
      noise        = {$urandom, $urandom};
      req          = noise[$bits(ftc_pkg::cal_req_t)-1:0];
      req.req_type = ftc_pkg::REQ_TICK;
      send_request(req);
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("fat_timestamp_calendar_counter_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [63:0]       raw;
    ftc_pkg::cal_req_t raw_req;
    int unsigned       random_base;
    int unsigned       pick;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = ftc_pkg::REQ_TICK;
    in_set_year   = '0;
    in_set_month  = '0;
    in_set_day    = '0;
    in_set_hour   = '0;
    in_set_minute = '0;
    in_set_second = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first beat ticks straight from the cleared calendar
    tick_times(1);
    load_time(1980, 1, 1, 0, 0, 0);
    // all-ones fields, then the two-second units wrap without a carry
    load_time(4095, 15, 31, 31, 63, 63);
    tick_times(1);
    load_time(0, 0, 0, 0, 0, 0);
    // last second of the last year, offset wraps to zero
    load_time(2107, 12, 31, 23, 59, 59);
    tick_times(1);
    // leap by the 400 rule, not leap by the 100 rule
    load_time(2000, 2, 28, 23, 59, 58);
    tick_times(1);
    load_time(2100, 2, 28, 23, 59, 58);
    tick_times(1);
    // day beyond the month length rolls over at midnight
    load_time(2023, 4, 31, 23, 59, 58);
    tick_times(1);
    load_time(2023, 9, 30, 23, 59, 58);
    tick_times(1);
    // month zero goes to january without a year carry, month 13 with one
    load_time(2023, 0, 31, 23, 59, 58);
    tick_times(1);
    load_time(2023, 13, 31, 23, 59, 58);
    tick_times(1);
    // day zero steps to one
    load_time(2023, 5, 0, 23, 59, 58);
    tick_times(1);
    // year below the epoch, hour beyond 23 wraps without a day carry
    load_time(1979, 6, 15, 31, 59, 58);
    tick_times(1);
    // minute beyond 59 wraps without an hour carry
    load_time(1990, 3, 10, 10, 63, 58);
    tick_times(1);

    random_base = beats_sent;
    while (beats_sent - random_base < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // sensible date parked close to a carry, then a short run of ticks
        load_time($urandom_range(1980, 2107), $urandom_range(1, 12),
                  $urandom_range(0, 3) != 0 ? $urandom_range(28, 31) : $urandom_range(1, 31),
                  $urandom_range(0, 3) != 0 ? 23 : $urandom_range(0, 23),
                  $urandom_range(0, 3) != 0 ? 59 : $urandom_range(0, 59),
                  $urandom_range(0, 3) != 0 ? 58 + $urandom_range(0, 1) : $urandom_range(0, 59));
        tick_times($urandom_range(1, 6));
      end else if (pick < 8) begin
        raw              = {$urandom, $urandom};
        raw_req          = raw[$bits(ftc_pkg::cal_req_t)-1:0];
        raw_req.req_type = ftc_pkg::REQ_LOAD;
        send_request(raw_req);
        tick_times($urandom_range(0, 3));
      end else begin
        tick_times($urandom_range(1, 10));
      end
    end
    burst_mode = 1'b0;
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("fat_timestamp_calendar_counter_tb: PASS");
    end else begin
      $display("fat_timestamp_calendar_counter_tb: FAIL");
    end
    $finish;
  end

endmodule
